/* hw/rtl/selective_repeat_receive_window_macros.svh */
// assertion helpers used by the receive window datapath
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

// property sampled on clk, ignored while rst_n is low
`define SRW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequence is checked in the cycle after the condition
`define SRW_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* hw/rtl/srw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw_pkg
// Field widths, result codes and controller/datapath signal groups of the
// selective-repeat receive window.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SEQ_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int WIN_W    = 5;
    localparam int STAT_W   = 2;

    // largest window and largest buffered count the 5-bit fields can carry
    localparam int WIN_MAX = 31;
    localparam logic [WIN_W-1:0] CNT_MAX   = 5'd31;
    localparam logic [WIN_W-1:0] WIN_RESET = 5'd31;

    localparam logic [STAT_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_DELIVERY = 1'b1;

    typedef struct packed {
        logic idle;
        logic eval;
        logic fetch;
        logic deliver;
    } srw_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic slot_free;
        logic next_set;
        logic more;
    } srw_sts_t;

    function automatic logic [WIN_W-1:0] free_slots_f(input logic [WIN_W-1:0] win,
                                                      input logic [WIN_W-1:0] cnt);
        return (win > cnt) ? (win - cnt) : '0;
    endfunction

endpackage

/* hw/rtl/srw_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw interfaces
// Valid/ready channels of the receive window: packet in, result out, window
// size write.
// ----------------------------------------------------------------------------
interface srw_pkt_if;
    import srw_pkg::*;
    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    seq_number;
    logic [HANDLE_W-1:0] packet_handle;
    modport source (output valid, output seq_number, output packet_handle, input ready);
    modport sink   (input valid, input seq_number, input packet_handle, output ready);
endinterface

interface srw_res_if;
    import srw_pkg::*;
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [STAT_W-1:0]   arrival_status;
    logic [SEQ_W-1:0]    delivered_seq;
    logic [HANDLE_W-1:0] delivered_handle;
    logic [WIN_W-1:0]    free_slots;
    logic                last_of_run;
    modport source (output valid, output result_kind, output arrival_status,
                    output delivered_seq, output delivered_handle, output free_slots,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input arrival_status,
                    input delivered_seq, input delivered_handle, input free_slots,
                    input last_of_run, output ready);
endinterface

interface srw_cfg_if;
    import srw_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

/* hw/rtl/srw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw_ctrl
// Sequencer: takes one request, evaluates it, then walks the in-order run
// one fetch and one delivery at a time.
// ----------------------------------------------------------------------------
module srw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  srw_pkg::srw_sts_t sts,
    output srw_pkg::srw_cmd_t cmd
);
    import srw_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EVAL    = 2'd1;
    localparam logic [1:0] S_FETCH   = 2'd2;
    localparam logic [1:0] S_DELIVER = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.in_fire)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.slot_free)
                    state_next = sts.next_set ? S_FETCH : S_IDLE;
            end
            S_FETCH:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (sts.slot_free)
                    state_next = sts.more ? S_FETCH : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.idle    = (state_reg == S_IDLE);
    assign cmd.eval    = (state_reg == S_EVAL) && sts.slot_free;
    assign cmd.fetch   = (state_reg == S_FETCH);
    assign cmd.deliver = (state_reg == S_DELIVER) && sts.slot_free;

endmodule

/* hw/rtl/srw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw_datapath
// Window state, received map, handle memory and the result register.
// ----------------------------------------------------------------------------
`include "selective_repeat_receive_window_macros.svh"

module srw_datapath #(
    parameter int MAX_WINDOW = 31,
    parameter int SEQ_SPACE  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  srw_pkg::srw_cmd_t cmd,
    output srw_pkg::srw_sts_t sts,
    srw_pkt_if.sink           pkt,
    srw_res_if.source         res,
    srw_cfg_if.sink           cfg
);
    import srw_pkg::*;

    localparam int IDX_W   = $clog2(SEQ_SPACE);
    localparam int DW      = IDX_W + 2;
    localparam int CAP_A   = (MAX_WINDOW < SEQ_SPACE - 1) ? MAX_WINDOW : SEQ_SPACE - 1;
    localparam int CAP_B   = (CAP_A < WIN_MAX) ? CAP_A : WIN_MAX;
    localparam logic [WIN_W-1:0] WIN_CAP  = WIN_W'(CAP_B);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEQ_SPACE - 1);

    // configuration and window state
    logic [WIN_W-1:0]     window_size_reg;
    logic [IDX_W-1:0]     last_reg;
    logic [WIN_W-1:0]     cnt_reg;
    logic [WIN_W-1:0]     run_reg;
    logic [SEQ_SPACE-1:0] map_reg;

    // captured request
    logic [SEQ_W-1:0]    seq_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // handle memory
    logic [HANDLE_W-1:0] handle_mem [SEQ_SPACE];
    logic [HANDLE_W-1:0] rdata_reg;

    // result register
    logic                out_valid_reg;
    logic                kind_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [SEQ_W-1:0]    dseq_reg;
    logic [HANDLE_W-1:0] dhandle_reg;
    logic [WIN_W-1:0]    free_reg;
    logic                last_of_run_reg;

    logic [WIN_W-1:0]  eff_win;
    logic [IDX_W-1:0]  seq_idx;
    logic [IDX_W-1:0]  next_idx;
    logic              in_range;
    logic [DW-1:0]     d_raw;
    logic [DW-1:0]     d_mod;
    logic              in_win;
    logic              dup;
    logic              accept;
    logic [STAT_W-1:0] status;
    logic [WIN_W-1:0]  cnt_eval;
    logic [WIN_W-1:0]  cnt_fetch;
    logic              slot_free;

    assign eff_win  = (window_size_reg > WIN_CAP) ? WIN_CAP : window_size_reg;
    assign seq_idx  = seq_reg[IDX_W-1:0];
    assign next_idx = (last_reg == IDX_LAST) ? '0 : last_reg + 1'b1;
    assign in_range = ({1'b0, seq_reg} < (SEQ_W + 1)'(SEQ_SPACE));

    // (seq - last - 1) mod space, one conditional subtract
    assign d_raw  = DW'(seq_idx) + DW'(SEQ_SPACE - 1) - DW'(last_reg);
    assign d_mod  = (d_raw >= DW'(SEQ_SPACE)) ? d_raw - DW'(SEQ_SPACE) : d_raw;
    assign in_win = in_range && (d_mod < DW'(eff_win));
    assign dup    = in_win && map_reg[seq_idx];
    assign accept = in_win && !map_reg[seq_idx];

    always_comb
    begin
        if (!in_win)
            status = ST_OUTSIDE;
        else if (dup)
            status = ST_DUPLICATE;
        else
            status = ST_ACCEPTED;
    end

    assign cnt_eval  = (accept && (cnt_reg != CNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_fetch = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
    assign slot_free = !out_valid_reg || res.ready;

    assign sts.in_fire   = pkt.valid && pkt.ready;
    assign sts.slot_free = slot_free;
    assign sts.next_set  = map_reg[next_idx] || (accept && (seq_idx == next_idx));
    assign sts.more      = map_reg[next_idx] && (run_reg != CNT_MAX);

    assign pkt.ready = cmd.idle;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (sts.in_fire)
        begin
            seq_reg    <= pkt.seq_number;
            handle_reg <= pkt.packet_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && accept)
            handle_mem[seq_idx] <= handle_reg;
        if (cmd.fetch)
            rdata_reg <= handle_mem[next_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_RESET;
            last_reg        <= IDX_LAST;
            cnt_reg         <= '0;
            run_reg         <= '0;
            map_reg         <= '0;
        end
        else
        begin
            if (cfg.valid)
                window_size_reg <= cfg.window_size;
            if (cmd.eval)
            begin
                run_reg <= '0;
                cnt_reg <= cnt_eval;
                if (accept)
                    map_reg[seq_idx] <= 1'b1;
            end
            if (cmd.fetch)
            begin
                map_reg[next_idx] <= 1'b0;
                last_reg          <= next_idx;
                cnt_reg           <= cnt_fetch;
                run_reg           <= run_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.eval || cmd.deliver)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            kind_reg        <= KIND_STATUS;
            status_reg      <= status;
            dseq_reg        <= '0;
            dhandle_reg     <= '0;
            free_reg        <= free_slots_f(eff_win, cnt_eval);
            last_of_run_reg <= !sts.next_set;
        end
        else if (cmd.deliver)
        begin
            kind_reg        <= KIND_DELIVERY;
            status_reg      <= ST_ACCEPTED;
            dseq_reg        <= SEQ_W'(last_reg);
            dhandle_reg     <= rdata_reg;
            free_reg        <= free_slots_f(eff_win, cnt_reg);
            last_of_run_reg <= !sts.more;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.result_kind      = kind_reg;
    assign res.arrival_status   = status_reg;
    assign res.delivered_seq    = dseq_reg;
    assign res.delivered_handle = dhandle_reg;
    assign res.free_slots       = free_reg;
    assign res.last_of_run      = last_of_run_reg;

    // the slot of the last delivered number is never held
    `SRW_ASSERT(a_last_clear, !map_reg[last_reg], "slot of last delivered number is set")
    // a fetch only ever releases a held packet
    `SRW_ASSERT(a_fetch_held, !cmd.fetch || map_reg[next_idx], "fetch of an empty slot")
    // each request is evaluated exactly once
    `SRW_ASSERT_NEXT(a_eval_once, cmd.eval, !cmd.eval, "request evaluated twice")

endmodule

/* hw/rtl/selective_repeat_receive_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive window of a selective-repeat link: window test, duplicate flag,
// handle store and in-order release of the held run.
// ----------------------------------------------------------------------------
//  channel   dir  moves
//  pkt       in   seq_number, packet_handle
//  res       out  one status result, then 0 to 31 delivery results
//  cfg       in   window_size write, always ready
//
//  a request is evaluated, then each released packet takes a fetch from the
//  handle memory port, then a load of the result register
//  pkt is ready again once the last result of the run is loaded
//  a stall on res holds the sequencer at the next result to load
//  reset clears the received map in flip-flops at once, no clearing pass
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
    parameter int MAX_WINDOW = 31,
    parameter int SEQ_SPACE  = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    srw_pkt_if.sink   pkt,
    srw_res_if.source res,
    srw_cfg_if.sink   cfg
);
    import srw_pkg::*;

    srw_cmd_t cmd;
    srw_sts_t sts;

    srw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    srw_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_SPACE  (SEQ_SPACE)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .pkt   (pkt),
        .res   (res),
        .cfg   (cfg)
    );

endmodule
